@@ src/rsc_pkg.sv @@
// Shared types, status codes and constants for the packet reassembly sequence checker.
// No dependencies.
package rsc_pkg;

  localparam int unsigned BUF_W = 18;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned OFF_W = 32;
  localparam int unsigned HDR_W = 32;

  localparam logic [BUF_W-1:0] MAX_BUFFER_BYTES = 18'h20000;
  localparam logic [BUF_W-1:0] BUFFER_LENGTH_RST = 18'h20000;
  localparam logic [LEN_W-1:0] MTU_RST = 16'd1400;

  localparam int unsigned IN_TDATA_W = 80;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [0:0] CFG_IDX_BUFFER_LENGTH = 1'b0;
  localparam logic [0:0] CFG_IDX_MTU = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RECV      = 3'd1,
    ST_TRUNC     = 3'd2,
    ST_SMALL     = 3'd3,
    ST_ORDER     = 3'd4,
    ST_FIRSTLAST = 3'd5,
    ST_HALTED    = 3'd6
  } status_t;

  typedef struct packed {
    logic [BUF_W-1:0] buffer_length;
    logic [LEN_W-1:0] mtu;
  } cfg_t;

  typedef struct packed {
    logic [HDR_W-1:0] header_word0;
    logic [OFF_W-1:0] offset_word;
    logic [LEN_W-1:0] payload_bytes;
    logic             recv_error;
  } item_t;

  typedef struct packed {
    status_t          status;
    logic             buffer_done;
    logic [BUF_W-1:0] buffer_bytes;
    logic             last_flag;
    logic [15:0]      data_id;
    logic [3:0]       version;
    logic [OFF_W-1:0] next_offset;
  } res_t;

endpackage

@@ src/rsc_cfg_regs.sv @@
// Configuration register file: buffer length and mtu.
// Depends on rsc_pkg.
module rsc_cfg_regs
  import rsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [BUF_W-1:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.buffer_length <= BUFFER_LENGTH_RST;
      cfg_r.mtu           <= MTU_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_BUFFER_LENGTH: cfg_r.buffer_length <= cfg_data;
        CFG_IDX_MTU:           cfg_r.mtu <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ src/rsc_check.sv @@
// Receive-error, sequence, space and first/last checks with the buffer tracking state.
// Depends on rsc_pkg.
module rsc_check
  import rsc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  item_t item,
  input  logic  fire,
  output res_t  res
);

  logic [OFF_W-1:0] exp_r, exp_nxt;
  logic             vfr_r, vfr_nxt;
  logic             start_r, start_nxt;
  logic [LEN_W-1:0] maxp_r, maxp_nxt;
  logic [BUF_W-1:0] rem_r, rem_nxt;
  logic [BUF_W-1:0] gath_r, gath_nxt;
  logic             halted_r, halted_nxt;

  logic [BUF_W-1:0] blen_sat;
  logic [BUF_W-1:0] rem_cur;
  logic [BUF_W-1:0] gath_cur;
  logic [BUF_W-1:0] len_ext;
  logic [BUF_W-1:0] rem_left;
  logic [LEN_W-1:0] maxp_eff;
  logic             pkt_first;
  logic             pkt_last;
  logic             bad_fl;
  status_t          status;
  logic             done;

  assign pkt_first = item.header_word0[14];
  assign pkt_last  = item.header_word0[15];
  assign blen_sat  = (cfg.buffer_length > MAX_BUFFER_BYTES) ? MAX_BUFFER_BYTES
                                                            : cfg.buffer_length;
  assign rem_cur   = start_r ? blen_sat : rem_r;
  assign gath_cur  = start_r ? '0 : gath_r;
  assign len_ext   = {{(BUF_W-LEN_W){1'b0}}, item.payload_bytes};
  assign rem_left  = rem_cur - len_ext;
  assign maxp_eff  = start_r ? item.payload_bytes : maxp_r;
  assign bad_fl    = start_r ? (vfr_r && !pkt_first) : pkt_first;

  always_comb begin
    exp_nxt    = exp_r;
    vfr_nxt    = vfr_r;
    start_nxt  = start_r;
    maxp_nxt   = maxp_r;
    rem_nxt    = rem_r;
    gath_nxt   = gath_r;
    halted_nxt = halted_r;
    status     = ST_HALTED;
    done       = 1'b0;
    if (!halted_r) begin
      rem_nxt  = rem_cur;
      gath_nxt = gath_cur;
      if (start_r && (blen_sat < {{(BUF_W-LEN_W){1'b0}}, cfg.mtu})) begin
        halted_nxt = 1'b1;
        status     = ST_SMALL;
      end else if (item.recv_error) begin
        halted_nxt = 1'b1;
        status     = ST_RECV;
      end else if (len_ext > rem_cur) begin
        halted_nxt = 1'b1;
        status     = ST_TRUNC;
      end else begin
        rem_nxt  = rem_left;
        gath_nxt = gath_cur + len_ext;
        if (item.offset_word != exp_r) begin
          halted_nxt = 1'b1;
          status     = ST_ORDER;
        end else begin
          exp_nxt   = exp_r + OFF_W'(1);
          maxp_nxt  = maxp_eff;
          start_nxt = 1'b0;
          if (bad_fl) begin
            halted_nxt = 1'b1;
            status     = ST_FIRSTLAST;
          end else begin
            status = ST_OK;
            if (pkt_last || (rem_left < {{(BUF_W-LEN_W){1'b0}}, maxp_eff})) begin
              done      = 1'b1;
              start_nxt = 1'b1;
              vfr_nxt   = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r    <= '0;
      vfr_r    <= 1'b1;
      start_r  <= 1'b1;
      maxp_r   <= '0;
      rem_r    <= '0;
      gath_r   <= '0;
      halted_r <= 1'b0;
    end else if (fire) begin
      exp_r    <= exp_nxt;
      vfr_r    <= vfr_nxt;
      start_r  <= start_nxt;
      maxp_r   <= maxp_nxt;
      rem_r    <= rem_nxt;
      gath_r   <= gath_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_comb begin
    res.status       = status;
    res.buffer_done  = done;
    res.buffer_bytes = gath_nxt;
    res.last_flag    = pkt_last;
    res.data_id      = item.header_word0[31:16];
    res.version      = item.header_word0[3:0];
    res.next_offset  = exp_nxt;
  end

endmodule

@@ src/packet_reassembly_sequence_checker_unit.sv @@
// Top level of the packet reassembly sequence checker: input and result registers.
// Depends on rsc_pkg, rsc_cfg_regs and rsc_check.
//
// Usage:
//   in_*  : one received packet per transaction. tdata carries header word 0,
//           the offset word and the payload length; tuser carries the receive
//           error flag.
//   out_* : one result per packet, in order. tuser is the status code, tlast
//           marks the packet that completes a buffer.
//   cfg_* : register writes (0 buffer length, 1 mtu), always ready; write only
//           while no packet is in flight.
//   Path: a packet that is taken is held in the input register and checked
//   from there; its result is captured in the result register and presented
//   on out_*. Throughput is one packet per cycle while out_tready is high; the
//   check runs between the input register and the result register.
//   When out_tready is low the result holds; the input register still takes
//   one more packet if it is empty, then in_tready drops until the result is taken.
//   Reset: synchronous, active low. Clears both stages, the tracking state and
//   the halt, and restores buffer length 131072 and mtu 1400.
//   Any error halts the block; later packets report the halted status until
//   reset.
module packet_reassembly_sequence_checker_unit
  import rsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // header_word0, offset_word, payload_bytes
  input  logic                   in_tuser,   // recv_error
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // buffer_bytes, last_flag, data_id,
                                             // version, next_offset, zero pad
  output logic [2:0]             out_tuser,  // status
  output logic                   out_tlast,  // buffer_done
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [0:0]             cfg_index,
  input  logic [BUF_W-1:0]       cfg_data
);

  cfg_t  cfg;
  item_t item_r;
  logic  in_valid_r;
  res_t  res;
  res_t  res_r;
  logic  out_valid_r;
  logic  advance;
  logic  fire;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  rsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rsc_check u_check (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (item_r),
    .fire  (fire),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.header_word0  <= in_tdata[31:0];
      item_r.offset_word   <= in_tdata[63:32];
      item_r.payload_bytes <= in_tdata[79:64];
      item_r.recv_error    <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.status;
  assign out_tlast  = res_r.buffer_done;
  assign out_tdata  = {1'b0, res_r.next_offset, res_r.version, res_r.data_id,
                       res_r.last_flag, res_r.buffer_bytes};

endmodule

@@ src/rsc_port_checker.sv @@
// Port-level checks for the packet reassembly sequence checker, bound to the top level.
// Depends on rsc_pkg and packet_reassembly_sequence_checker_unit.
module rsc_port_checker
  import rsc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [2:0]             out_tuser,
  input logic                   out_tlast,
  input logic                   cfg_ready
);

  a_done_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == ST_OK)
    else $error("buffer end reported with a nonzero status");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser != ST_OK
      |=> !out_tvalid || out_tuser == ST_HALTED)
    else $error("result after an error is not the halted status");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && cfg_ready)
    else $error("result valid right after reset");

  a_no_block_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !in_tready |=> out_tvalid)
    else $error("input stalled while result stage empty");

endmodule

bind packet_reassembly_sequence_checker_unit rsc_port_checker u_rsc_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .cfg_ready  (cfg_ready)
);
